FILE: rtl/lpht_pkg.sv
// Shared types and constants for the linear probe hash table.
`timescale 1ns / 1ps
package lpht_pkg;
   localparam int SLOT_BITS  = 10;
   localparam int SLOTS      = 1 << SLOT_BITS;
   localparam int KEY_BITS   = 48;
   localparam int VALUE_BITS = 16;
   localparam int CAP_BITS   = 4;
   localparam int OCC_BITS   = 11;
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;

   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]            mode;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] result_value;
      logic [1:0]            status;
      logic [SLOT_BITS-1:0]  slot_index;
   } rsp_type;

   // Effective slot mask from the capacity register.
   function automatic logic [SLOT_BITS-1:0] cap_mask(input logic [CAP_BITS-1:0] n);
      logic [CAP_BITS-1:0] e;
      begin
         e = n;
         if (e < CAP_BITS'(2)) e = CAP_BITS'(2);
         if (e > CAP_BITS'(SLOT_BITS)) e = CAP_BITS'(SLOT_BITS);
         cap_mask = SLOT_BITS'((32'd1 << e) - 32'd1);
      end
   endfunction
endpackage

FILE: rtl/lpht_if.sv
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface lpht_req_if;
   logic              valid;
   logic              ready;
   lpht_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lpht_rsp_if;
   logic              valid;
   logic              ready;
   lpht_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/lpht_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

FILE: rtl/linear_probe_hash_table.sv
// Top level of the linear probe hash table.
`timescale 1ns / 1ps
// Open-addressing hash table of 1024 slots (48-bit key, 16-bit handle per
// slot), hash (key>>3)&mask with linear probing. One request at a time.
// After reset a clearing pass writes every slot invalid, and ready stays
// low until it ends. The valid bit lives in the slot RAM next to key and
// handle. Each probed slot takes a RAM read, then a compare. A delete
// scans the following slots for backward shift (step, read, compare) and
// moves each entry that must move (copy, then clear).
module linear_probe_hash_table (
   input  logic                          clock,
   input  logic                          reset,
   lpht_req_if.sink                      req,
   lpht_rsp_if.source                    rsp,
   input  logic                          csr_wr_en,
   input  logic [lpht_pkg::CAP_BITS-1:0] csr_wr_data
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_CMP, ST_SH_STEP, ST_SH_READ, ST_SH_CMP,
      ST_SH_WRITE, ST_SH_CLEAR, ST_DONE
   } state_type;

   localparam int SB = lpht_pkg::SLOT_BITS;
   localparam int RW = lpht_pkg::ENTRY_BITS + 1;

   state_type                         state_ff;
   logic [lpht_pkg::CAP_BITS-1:0]     cap_ff;
   logic [lpht_pkg::OCC_BITS-1:0]     occ_ff;
   lpht_pkg::req_type                 req_ff;
   lpht_pkg::rsp_type                 rsp_ff;
   logic [SB-1:0]                     mask_ff;
   logic [SB-1:0]                     h_ff, i_ff, j_ff;
   logic [SB:0]                       n_ff;
   logic [SB-1:0]                     addr;
   logic                              wr_en;
   logic [RW-1:0]                     wr_data, rd_data;
   logic                              rd_valid;
   logic [lpht_pkg::KEY_BITS-1:0]     rd_key;
   logic [lpht_pkg::VALUE_BITS-1:0]   rd_val;
   logic [SB-1:0]                     r_hash;
   logic                              stay;

   assign rd_valid = rd_data[RW-1];
   assign rd_key   = rd_data[lpht_pkg::ENTRY_BITS-1:lpht_pkg::VALUE_BITS];
   assign rd_val   = rd_data[lpht_pkg::VALUE_BITS-1:0];
   assign r_hash   = SB'(rd_key >> 3) & mask_ff;
   // Entry at i stays when its home r lies cyclically in (j, i].
   assign stay = ((j_ff < r_hash) && (r_hash <= i_ff)) ||
                 ((i_ff < j_ff) && (j_ff < r_hash)) ||
                 ((r_hash <= i_ff) && (i_ff < j_ff));

   // RAM port selection
   always_comb begin
      wr_en   = 1'b0;
      addr    = h_ff;
      wr_data = {1'b1, req_ff.key, req_ff.entry_value};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
         end
         ST_SH_READ, ST_SH_CMP: addr = i_ff;
         ST_SH_WRITE: begin
            addr    = j_ff;
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         ST_SH_CLEAR: begin
            addr    = i_ff;
            wr_en   = 1'b1;
            wr_data = '0;
         end
         ST_CMP: begin
            if (req_ff.mode == lpht_pkg::MODE_INSERT) begin
               wr_en = !rd_valid;
            end else if (req_ff.mode == lpht_pkg::MODE_DELETE && rd_valid &&
                         rd_key == req_ff.key) begin
               wr_en   = 1'b1;
               wr_data = '0;
            end
         end
         default: addr = h_ff;
      endcase
   end

   lpht_ram #(.WIDTH(RW), .DEPTH(lpht_pkg::SLOTS)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = (state_ff == ST_DONE);
   assign rsp.payload = rsp_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cap_ff   <= lpht_pkg::CAP_BITS'(10);
         occ_ff   <= '0;
         h_ff     <= '0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         case (state_ff)
            // Clearing pass: one slot per cycle
            ST_CLEAR: begin
               h_ff <= h_ff + 1'b1;
               if (h_ff == '1) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req.valid) begin
                  req_ff   <= req.payload;
                  mask_ff  <= lpht_pkg::cap_mask(cap_ff);
                  h_ff     <= SB'(req.payload.key >> 3) & lpht_pkg::cap_mask(cap_ff);
                  n_ff     <= '0;
                  rsp_ff   <= '{found: 1'b0, result_value: '0,
                                status: lpht_pkg::STATUS_NOT_FOUND, slot_index: '0};
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (n_ff > {1'b0, mask_ff}) begin
                  if (req_ff.mode == lpht_pkg::MODE_INSERT)
                     rsp_ff.status <= lpht_pkg::STATUS_FULL;
                  state_ff <= ST_DONE;
               end else if (req_ff.mode != lpht_pkg::MODE_LOOKUP &&
                            req_ff.mode != lpht_pkg::MODE_INSERT &&
                            req_ff.mode != lpht_pkg::MODE_DELETE) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               if (req_ff.mode == lpht_pkg::MODE_INSERT) begin
                  if (!rd_valid) begin
                     occ_ff               <= occ_ff + 1'b1;
                     rsp_ff.status        <= lpht_pkg::STATUS_OK;
                     rsp_ff.slot_index    <= h_ff;
                     state_ff             <= ST_DONE;
                  end else begin
                     h_ff     <= (h_ff + 1'b1) & mask_ff;
                     n_ff     <= n_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end else if (!rd_valid) begin
                  state_ff <= ST_DONE;
               end else if (rd_key == req_ff.key) begin
                  rsp_ff.found      <= 1'b1;
                  rsp_ff.status     <= lpht_pkg::STATUS_OK;
                  rsp_ff.slot_index <= h_ff;
                  if (req_ff.mode == lpht_pkg::MODE_DELETE) begin
                     occ_ff         <= occ_ff - 1'b1;
                     i_ff           <= h_ff;
                     j_ff           <= h_ff;
                     n_ff           <= '0;
                     state_ff       <= ST_SH_STEP;
                  end else begin
                     rsp_ff.result_value <= rd_val;
                     state_ff            <= ST_DONE;
                  end
               end else begin
                  h_ff     <= (h_ff + 1'b1) & mask_ff;
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            // Backward shift: advance i, read it, move it to j if needed
            ST_SH_STEP: begin
               if (n_ff > {1'b0, mask_ff}) begin
                  state_ff <= ST_DONE;
               end else begin
                  i_ff     <= (i_ff + 1'b1) & mask_ff;
                  n_ff     <= n_ff + 1'b1;
                  state_ff <= ST_SH_READ;
               end
            end
            ST_SH_READ: begin
               state_ff <= ST_SH_CMP;
            end
            ST_SH_CMP: begin
               if (!rd_valid) state_ff <= ST_DONE;
               else           state_ff <= stay ? ST_SH_STEP : ST_SH_WRITE;
            end
            ST_SH_WRITE: begin
               state_ff <= ST_SH_CLEAR;
            end
            // Old slot of the moved entry becomes the new gap
            ST_SH_CLEAR: begin
               j_ff     <= i_ff;
               state_ff <= ST_SH_STEP;
            end
            ST_DONE: begin
               if (rsp.ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/lpht_checker.sv
// Port-level assertions for the linear probe hash table, bound to the top.
`timescale 1ns / 1ps
module lpht_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lpht_pkg::rsp_type rsp_payload
);
   // One request at a time: never ready while a response is pending.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready with response pending");

   // A taken request is followed by a busy period.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");

   // Found implies ok status.
   a_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.found) |-> rsp_payload.status == lpht_pkg::STATUS_OK)
      else $error("found without ok");

   // Stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped");
endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

FILE: tb/sv/linear_probe_hash_table_test.sv
// Self-checking testbench for the linear probe hash table top level.
`timescale 1ns / 1ps
module linear_probe_hash_table_test;
   localparam int IDLE_LIMIT = 50000;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   // Table contents shadow and expected-response store
   class hash_scoreboard;
      logic [lpht_pkg::KEY_BITS-1:0]   shadow_key   [lpht_pkg::SLOTS];
      logic [lpht_pkg::VALUE_BITS-1:0] shadow_value [lpht_pkg::SLOTS];
      bit                              shadow_used  [lpht_pkg::SLOTS];
      int unsigned                     cap_log2;
      lpht_pkg::rsp_type               pending_rsp [$];
      int                              mismatches;

      function new();
         foreach (shadow_used[i]) begin
            shadow_used[i]  = 0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
         end
         cap_log2   = 10;
         mismatches = 0;
      endfunction

      function void set_capacity(int unsigned n);
         cap_log2 = n & 15;
      endfunction

      function int unsigned slots_in_use();
         int unsigned n;
         n = cap_log2;
         if (n < 2) n = 2;
         if (n > lpht_pkg::SLOT_BITS) n = lpht_pkg::SLOT_BITS;
         return 1 << n;
      endfunction

      function int unsigned home_slot(logic [lpht_pkg::KEY_BITS-1:0] k, int unsigned mask);
         return int'(k[lpht_pkg::SLOT_BITS+2:3]) & mask;
      endfunction

      // Probe for a key; returns slot or -1
      function int locate(logic [lpht_pkg::KEY_BITS-1:0] k, int unsigned cap);
         int unsigned h;
         h = home_slot(k, cap - 1);
         for (int n = 0; n < cap; n++) begin
            if (!shadow_used[h]) return -1;
            if (shadow_key[h] == k) return h;
            h = (h + 1) & (cap - 1);
         end
         return -1;
      endfunction

      // Backward-shift deletion starting at the vacated slot
      function void close_gap(int unsigned start, int unsigned cap);
         int unsigned mask, i, j, r;
         mask = cap - 1;
         i = start;
         j = start;
         shadow_used[j] = 0;
         for (int n = 0; n < cap; n++) begin
            i = (i + 1) & mask;
            if (!shadow_used[i]) return;
            r = home_slot(shadow_key[i], mask);
            if ((j < r && r <= i) || (i < j && j < r) || (r <= i && i < j)) continue;
            shadow_key[j]   = shadow_key[i];
            shadow_value[j] = shadow_value[i];
            shadow_used[j]  = 1;
            shadow_used[i]  = 0;
            j = i;
         end
      endfunction

      // Apply an accepted request and queue its response
      function void note_request(lpht_pkg::req_type r);
         lpht_pkg::rsp_type e;
         int unsigned       cap, h;
         int                w;
         cap = slots_in_use();
         e.found = 0;
         e.result_value = '0;
         e.status = lpht_pkg::STATUS_NOT_FOUND;
         e.slot_index = '0;
         case (r.mode)
            lpht_pkg::MODE_LOOKUP: begin
               w = locate(r.key, cap);
               if (w >= 0) begin
                  e.found = 1;
                  e.result_value = shadow_value[w];
                  e.status = lpht_pkg::STATUS_OK;
                  e.slot_index = w[lpht_pkg::SLOT_BITS-1:0];
               end
            end
            lpht_pkg::MODE_INSERT: begin
               e.status = lpht_pkg::STATUS_FULL;
               h = home_slot(r.key, cap - 1);
               for (int n = 0; n < cap; n++) begin
                  if (!shadow_used[h]) begin
                     shadow_key[h]   = r.key;
                     shadow_value[h] = r.entry_value;
                     shadow_used[h]  = 1;
                     e.status = lpht_pkg::STATUS_OK;
                     e.slot_index = h[lpht_pkg::SLOT_BITS-1:0];
                     break;
                  end
                  h = (h + 1) & (cap - 1);
               end
            end
            lpht_pkg::MODE_DELETE: begin
               w = locate(r.key, cap);
               if (w >= 0) begin
                  close_gap(w, cap);
                  e.found = 1;
                  e.status = lpht_pkg::STATUS_OK;
                  e.slot_index = w[lpht_pkg::SLOT_BITS-1:0];
               end
            end
            default: ;
         endcase
         pending_rsp.push_back(e);
      endfunction

      function void check_response(lpht_pkg::rsp_type got);
         lpht_pkg::rsp_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         e = pending_rsp.pop_front();
         if (got.found !== e.found || got.result_value !== e.result_value ||
             got.status !== e.status || got.slot_index !== e.slot_index) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch: expected found=%0d value=%h status=%0d slot=%0d",
                        e.found, e.result_value, e.status, e.slot_index);
               $display("                   got      found=%0d value=%h status=%0d slot=%0d",
                        got.found, got.result_value, got.status, got.slot_index);
            end
         end
      endfunction
   endclass

   logic                          clock = 0;
   logic                          reset;
   logic                          csr_wr_en;
   logic [lpht_pkg::CAP_BITS-1:0] csr_wr_data;

   lpht_req_if req_ch();
   lpht_rsp_if rsp_ch();

   linear_probe_hash_table DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   hash_scoreboard sb = new();

   logic [lpht_pkg::KEY_BITS-1:0] key_pool [$];
   bit                            no_gaps;
   int                            idle_cycles;

   always #5 clock = ~clock;

   initial begin
      reset <= 1;
      csr_wr_en <= 0;
      csr_wr_data <= '0;
      req_ch.valid <= 0;
      req_ch.payload <= '0;
      rsp_ch.ready <= 0;
   end

   // Gap length: mostly short, a few long
   function automatic int pick_gap();
      if (no_gaps) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(10, 40);
   endfunction

   // Response-side stalls
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
      end
   end

   // Response monitor and idle watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles <= 0;
         else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("** linear_probe_hash_table: FAILED **");
            $finish;
         end else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Send one request and hold it until accepted
   task automatic send_request(logic [1:0] mode, logic [lpht_pkg::KEY_BITS-1:0] k,
                               logic [lpht_pkg::VALUE_BITS-1:0] v);
      lpht_pkg::req_type r;
      int                gap;
      r.mode = mode;
      r.key = k;
      r.entry_value = v;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(r);
      if (mode == lpht_pkg::MODE_INSERT) begin
         key_pool.push_back(k);
         if (key_pool.size() > 48) void'(key_pool.pop_front());
      end
   endtask

   // Drop valid and wait for all responses
   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [lpht_pkg::CAP_BITS-1:0] n);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_capacity(n);
      @(posedge clock);
   endtask

   // Fresh key, often clustered on a few home slots
   function automatic logic [lpht_pkg::KEY_BITS-1:0] fresh_key();
      logic [lpht_pkg::KEY_BITS-1:0] k;
      k = lpht_pkg::KEY_BITS'({$urandom, $urandom});
      if ($urandom_range(0, 1)) k[12:3] = 10'($urandom_range(0, 15));
      return k;
   endfunction

   function automatic logic [lpht_pkg::KEY_BITS-1:0] some_key();
      if (key_pool.size() > 0 && $urandom_range(0, 9) < 7)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return fresh_key();
   endfunction

   task automatic random_phase(int count);
      int                              sel;
      logic [1:0]                      mode;
      logic [lpht_pkg::VALUE_BITS-1:0] v;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 59) == 0) drain();
         sel = $urandom_range(0, 99);
         if (sel < 40) mode = lpht_pkg::MODE_INSERT;
         else if (sel < 70) mode = lpht_pkg::MODE_LOOKUP;
         else if (sel < 95) mode = lpht_pkg::MODE_DELETE;
         else mode = MODE_RESERVED;
         v = 16'($urandom);
         if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? '1 : '0;
         send_request(mode, some_key(), v);
      end
   endtask

   initial begin
      idle_cycles = 0;
      no_gaps = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, each mode, absent keys, unused mode
      send_request(lpht_pkg::MODE_LOOKUP, '1, '0);
      send_request(lpht_pkg::MODE_INSERT, '1, '1);
      send_request(lpht_pkg::MODE_INSERT, '0, '0);
      send_request(lpht_pkg::MODE_LOOKUP, '1, '0);
      send_request(lpht_pkg::MODE_LOOKUP, '0, '1);
      send_request(MODE_RESERVED, '1, '1);
      send_request(lpht_pkg::MODE_DELETE, '1, '0);
      send_request(lpht_pkg::MODE_DELETE, '1, '0);
      send_request(lpht_pkg::MODE_LOOKUP, '1, '0);
      send_request(lpht_pkg::MODE_INSERT, 48'h0000_0000_1FF8, 16'h5A5A);

      // Smallest table: wrap, full, duplicate keys, backward shift
      write_capacity(4'd2);
      send_request(lpht_pkg::MODE_INSERT, 48'h18, 16'h0001);
      send_request(lpht_pkg::MODE_INSERT, 48'h38, 16'h0002);
      send_request(lpht_pkg::MODE_INSERT, 48'h18, 16'h0003);
      send_request(lpht_pkg::MODE_INSERT, 48'h10, 16'h0004);
      send_request(lpht_pkg::MODE_INSERT, 48'h20, 16'h0005);
      send_request(lpht_pkg::MODE_INSERT, 48'h28, 16'h0006);
      send_request(lpht_pkg::MODE_LOOKUP, 48'h28, 16'h0000);
      send_request(lpht_pkg::MODE_DELETE, 48'h18, 16'h0000);
      send_request(lpht_pkg::MODE_LOOKUP, 48'h38, 16'h0000);
      send_request(lpht_pkg::MODE_LOOKUP, 48'h40, 16'h0000);

      // Capacity changes while entries remain, including out-of-range values
      write_capacity(4'd0);
      random_phase(60);
      write_capacity(4'd3);
      random_phase(70);
      write_capacity(4'd10);
      random_phase(80);
      write_capacity(4'd15);
      random_phase(60);
      write_capacity(4'd1);
      random_phase(60);
      write_capacity(4'd5);
      random_phase(70);

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
         $display("** linear_probe_hash_table: PASSED **");
      else
         $display("** linear_probe_hash_table: FAILED **");
      $finish;
   end
endmodule

FILE: linear_probe_hash_table.f
rtl/lpht_pkg.sv
rtl/lpht_if.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
tb/sv/linear_probe_hash_table_test.sv
